@@ rtl/lms2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local maximum suppression package
// Shared constants, register indexes, codes and types of the suppression block.
// ----------------------------------------------------------------------------
package lms2d_pkg;

    localparam int MAX_HEIGHT_DEF  = 128;
    localparam int MAX_WIDTH_DEF   = 128;
    localparam int MAX_KERNEL_DEF  = 9;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ROW_W       = 7;
    localparam int COL_W       = 7;
    localparam int KSIZE_W     = 4;
    localparam int PLANE_W     = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIDE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_WIDTH  = 2'd2;

    localparam logic [KSIZE_W-1:0] WINDOW_SIDE_RST  = 4'd3;
    localparam logic [PLANE_W-1:0] PLANE_HEIGHT_RST = 8'd128;
    localparam logic [PLANE_W-1:0] PLANE_WIDTH_RST  = 8'd128;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_BOUNDS,
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } walk_ctrl_t;

    typedef struct packed
    {
        logic outside;
        logic last;
    } walk_stat_t;

endpackage

@@ rtl/lms2d_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local maximum suppression channels
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface lms2d_in_if #(
    parameter int SAMPLE_BITS = lms2d_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [lms2d_pkg::ROW_W-1:0]     row;
    logic [lms2d_pkg::COL_W-1:0]     col;
    logic signed [SAMPLE_BITS-1:0]   pixel_value;

    modport source (output valid, output opcode, output row, output col,
                    output pixel_value, input ready);
    modport sink   (input valid, input opcode, input row, input col,
                    input pixel_value, output ready);
endinterface

interface lms2d_out_if #(
    parameter int SAMPLE_BITS = lms2d_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   kept_value;
    logic                            is_peak;

    modport source (output valid, output kept_value, output is_peak, input ready);
    modport sink   (input valid, input kept_value, input is_peak, output ready);
endinterface

@@ rtl/lms2d_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lms2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lms2d_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window walker
// Clamps the registers, computes the clipped window and steps through it.
// ----------------------------------------------------------------------------
module lms2d_walk #(
    parameter int MAX_HEIGHT = lms2d_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = lms2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = lms2d_pkg::MAX_KERNEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [lms2d_pkg::KSIZE_W-1:0]   window_side,
    input  logic [lms2d_pkg::PLANE_W-1:0]   plane_height,
    input  logic [lms2d_pkg::PLANE_W-1:0]   plane_width,
    input  logic [lms2d_pkg::ROW_W-1:0]     row,
    input  logic [lms2d_pkg::COL_W-1:0]     col,
    input  lms2d_pkg::walk_ctrl_t           ctrl,
    output lms2d_pkg::walk_stat_t           stat,
    output lms2d_pkg::coord_t               y,
    output lms2d_pkg::coord_t               x
);

    lms2d_pkg::coord_t kc, hc, wc, half, r, c, hs, ws, he, we;
    lms2d_pkg::coord_t y_reg, y_next, x_reg, x_next;
    lms2d_pkg::coord_t xs_reg, xs_next, ye_reg, ye_next, xe_reg, xe_next;

    always_comb
    begin
        if (window_side == '0)
            kc = lms2d_pkg::coord_t'(1);
        else if (int'(window_side) > MAX_KERNEL)
            kc = lms2d_pkg::coord_t'(MAX_KERNEL);
        else
            kc = lms2d_pkg::coord_t'(window_side);

        if (plane_height == '0)
            hc = lms2d_pkg::coord_t'(1);
        else if (int'(plane_height) > MAX_HEIGHT)
            hc = lms2d_pkg::coord_t'(MAX_HEIGHT);
        else
            hc = lms2d_pkg::coord_t'(plane_height);

        if (plane_width == '0)
            wc = lms2d_pkg::coord_t'(1);
        else if (int'(plane_width) > MAX_WIDTH)
            wc = lms2d_pkg::coord_t'(MAX_WIDTH);
        else
            wc = lms2d_pkg::coord_t'(plane_width);

        r    = lms2d_pkg::coord_t'(row);
        c    = lms2d_pkg::coord_t'(col);
        half = kc >> 1;
        hs   = (r >= half) ? r - half : '0;
        ws   = (c >= half) ? c - half : '0;
        he   = (hs + kc < hc) ? hs + kc : hc;
        we   = (ws + kc < wc) ? ws + kc : wc;

        stat.outside = (r >= hc) || (c >= wc);
        stat.last    = ((y_reg + lms2d_pkg::coord_t'(1)) == ye_reg)
                    && ((x_reg + lms2d_pkg::coord_t'(1)) == xe_reg);

        y_next  = y_reg;
        x_next  = x_reg;
        xs_next = xs_reg;
        ye_next = ye_reg;
        xe_next = xe_reg;
        if (ctrl.load)
        begin
            y_next  = hs;
            x_next  = ws;
            xs_next = ws;
            ye_next = he;
            xe_next = we;
        end
        else if (ctrl.step)
        begin
            if ((x_reg + lms2d_pkg::coord_t'(1)) == xe_reg)
            begin
                x_next = xs_reg;
                y_next = y_reg + lms2d_pkg::coord_t'(1);
            end
            else
            begin
                x_next = x_reg + lms2d_pkg::coord_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg  <= '0;
            x_reg  <= '0;
            xs_reg <= '0;
            ye_reg <= '0;
            xe_reg <= '0;
        end
        else
        begin
            y_reg  <= y_next;
            x_reg  <= x_next;
            xs_reg <= xs_next;
            ye_reg <= ye_next;
            xe_reg <= xe_next;
        end
    end

    assign y = y_reg;
    assign x = x_reg;

endmodule

@@ rtl/local_maximum_suppression_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-dimensional local maximum suppression
// Pixel store with a sequenced window scan that keeps only window maxima.
// ----------------------------------------------------------------------------
// A write word stores its score and gives no result. A query word scans its
// clipped window one pixel at a time, paced by the single read port of the pixel
// store and the one comparator that checks one window pixel per cycle; a query
// outside the plane goes from the bounds check straight to the finish step. The
// block takes one word at a time, and a finished result waits in an output
// register while the next word is taken; a query holds in its last cycle while
// the previous result is still waiting.
// The pixel store is not cleared after reset.
module local_maximum_suppression_2d #(
    parameter int MAX_HEIGHT  = lms2d_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH   = lms2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL  = lms2d_pkg::MAX_KERNEL_DEF,
    parameter int SAMPLE_BITS = lms2d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lms2d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lms2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    lms2d_in_if.sink                          item,
    lms2d_out_if.source                       result
);

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    lms2d_pkg::state_t state_reg, state_next;

    logic [lms2d_pkg::KSIZE_W-1:0] window_side_reg;
    logic [lms2d_pkg::PLANE_W-1:0] plane_height_reg, plane_width_reg;

    logic [lms2d_pkg::ROW_W-1:0] row_reg, row_next;
    logic [lms2d_pkg::COL_W-1:0] col_reg, col_next;
    logic signed [SAMPLE_BITS-1:0] centre_reg, centre_next;
    logic peak_reg, peak_next;
    logic pend_reg, pend_next;
    logic done_reg, done_next;

    logic out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] kept_reg, kept_next;
    logic is_peak_reg, is_peak_next;

    lms2d_pkg::walk_ctrl_t walk_ctrl;
    lms2d_pkg::walk_stat_t walk_stat;
    lms2d_pkg::coord_t     walk_y, walk_x, ry, rx;

    logic                    accept;
    logic                    ram_we;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic signed [SAMPLE_BITS-1:0] rd_data;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == lms2d_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_side_reg  <= lms2d_pkg::WINDOW_SIDE_RST;
            plane_height_reg <= lms2d_pkg::PLANE_HEIGHT_RST;
            plane_width_reg  <= lms2d_pkg::PLANE_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lms2d_pkg::CFG_WINDOW_SIDE:
                    window_side_reg <= cfg_data[lms2d_pkg::KSIZE_W-1:0];
                lms2d_pkg::CFG_PLANE_HEIGHT:
                    plane_height_reg <= cfg_data;
                lms2d_pkg::CFG_PLANE_WIDTH:
                    plane_width_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign ram_we = accept && (item.opcode == lms2d_pkg::OP_WRITE)
                 && (int'(item.row) < MAX_HEIGHT) && (int'(item.col) < MAX_WIDTH);
    assign waddr  = ADDR_W'(item.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(item.col);

    assign ry    = (state_reg == lms2d_pkg::ST_BOUNDS) ? lms2d_pkg::coord_t'(row_reg) : walk_y;
    assign rx    = (state_reg == lms2d_pkg::ST_BOUNDS) ? lms2d_pkg::coord_t'(col_reg) : walk_x;
    assign raddr = ADDR_W'(ry) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx);

    lms2d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (item.pixel_value),
        .raddr (raddr),
        .rdata (rd_data)
    );

    lms2d_walk #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_side  (window_side_reg),
        .plane_height (plane_height_reg),
        .plane_width  (plane_width_reg),
        .row          (row_reg),
        .col          (col_reg),
        .ctrl         (walk_ctrl),
        .stat         (walk_stat),
        .y            (walk_y),
        .x            (walk_x)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        centre_next    = centre_reg;
        peak_next      = peak_reg;
        pend_next      = 1'b0;
        done_next      = done_reg;
        walk_ctrl.load = 1'b0;
        walk_ctrl.step = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        kept_next      = kept_reg;
        is_peak_next   = is_peak_reg;

        case (state_reg)
            lms2d_pkg::ST_IDLE:
            begin
                if (accept && (item.opcode == lms2d_pkg::OP_QUERY))
                begin
                    row_next   = item.row;
                    col_next   = item.col;
                    state_next = lms2d_pkg::ST_BOUNDS;
                end
            end
            lms2d_pkg::ST_BOUNDS:
            begin
                done_next = 1'b0;
                if (walk_stat.outside)
                begin
                    peak_next  = 1'b0;
                    state_next = lms2d_pkg::ST_FINISH;
                end
                else
                begin
                    peak_next      = 1'b1;
                    walk_ctrl.load = 1'b1;
                    state_next     = lms2d_pkg::ST_LOAD;
                end
            end
            lms2d_pkg::ST_LOAD:
            begin
                centre_next    = rd_data;
                walk_ctrl.step = 1'b1;
                pend_next      = 1'b1;
                done_next      = walk_stat.last;
                state_next     = lms2d_pkg::ST_SCAN;
            end
            lms2d_pkg::ST_SCAN:
            begin
                if (pend_reg && (rd_data > centre_reg))
                begin
                    peak_next = 1'b0;
                end
                if (done_reg)
                begin
                    state_next = lms2d_pkg::ST_FINISH;
                end
                else
                begin
                    walk_ctrl.step = 1'b1;
                    pend_next      = 1'b1;
                    done_next      = walk_stat.last;
                end
            end
            lms2d_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    kept_next      = peak_reg ? centre_reg : '0;
                    is_peak_next   = peak_reg;
                    state_next     = lms2d_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lms2d_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lms2d_pkg::ST_IDLE;
            peak_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        centre_reg  <= centre_next;
        kept_reg    <= kept_next;
        is_peak_reg <= is_peak_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.kept_value = kept_reg;
    assign result.is_peak    = is_peak_reg;

`ifndef SYNTHESIS
    a_last_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lms2d_pkg::ST_SCAN && done_reg) |-> pend_reg)
        else $error("Window scan ended without its last read in flight.");

    a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_peak_reg) |-> (kept_reg == '0))
        else $error("Suppressed result carries a nonzero score.");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lms2d_pkg::ST_FINISH))
        else $error("Result appeared outside the finish step.");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == lms2d_pkg::ST_IDLE))
        else $error("Pixel store written during a query.");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local maximum suppression testbench
// Drives pixel writes and window queries into the suppression block, keeps its
// own copy of the pixel store and the size registers, predicts the kept score
// and peak flag of every query, and checks each result word in order. Both
// channels idle and stall in random bursts, and the sizes are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    import lms2d_pkg::*;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] score_t;

    typedef struct
    {
        score_t kept_value;
        logic   is_peak;
    } verdict_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam score_t SCORE_MAX      = 16'sh7FFF;
    localparam score_t SCORE_MIN      = 16'sh8000;
    localparam int     WORD_TARGET    = 1350;
    localparam int     QUIET_FROM     = WORD_TARGET - 150;
    localparam int     DRAIN_CYCLES   = 100;
    localparam int     WATCHDOG_LIMIT = 1000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lms2d_in_if  item_if ();
    lms2d_out_if result_if ();

    local_maximum_suppression_2d i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    score_t          score_store [0:MAX_HEIGHT_DEF-1][0:MAX_WIDTH_DEF-1];
    bit              written     [0:MAX_HEIGHT_DEF-1][0:MAX_WIDTH_DEF-1];
    logic [KSIZE_W-1:0] kernel_reg;
    logic [PLANE_W-1:0] height_reg;
    logic [PLANE_W-1:0] width_reg;
    verdict_t        pending_verdicts [$];
    int              words_sent;
    int              failures;
    int              idle_cycles;
    int              gap_pct;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int size_limit(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Returns 0 when the pixel lies outside the plane; the window is then empty.
    function automatic bit window_of(input int r, input int c, output int hs,
                                     output int he, output int ws, output int we);
        int k;
        int h;
        int w;
        int half;
        k = size_limit(int'(kernel_reg), MAX_KERNEL_DEF);
        h = size_limit(int'(height_reg), MAX_HEIGHT_DEF);
        w = size_limit(int'(width_reg), MAX_WIDTH_DEF);
        hs = 0;
        he = 0;
        ws = 0;
        we = 0;
        if (r >= h || c >= w)
            return 1'b0;
        half = k / 2;
        hs = (r >= half) ? r - half : 0;
        ws = (c >= half) ? c - half : 0;
        he = (hs + k < h) ? hs + k : h;
        we = (ws + k < w) ? ws + k : w;
        return 1'b1;
    endfunction

    function automatic verdict_t predict_suppression(input int r, input int c);
        verdict_t v;
        int hs;
        int he;
        int ws;
        int we;
        score_t centre;
        bit peak;
        v.kept_value = '0;
        v.is_peak = 1'b0;
        if (!window_of(r, c, hs, he, ws, we))
            return v;
        centre = score_store[r][c];
        peak = 1'b1;
        for (int y = hs; y < he; y++)
            for (int x = ws; x < we; x++)
                if (score_store[y][x] > centre)
                    peak = 1'b0;
        if (peak)
            v.kept_value = centre;
        v.is_peak = peak;
        return v;
    endfunction

    function automatic score_t random_score();
        int t;
        case ($urandom_range(0, 3))
            0:
            begin
                t = int'($urandom_range(0, 8)) - 4;
                return t[SAMPLE_BITS_DEF-1:0];
            end
            3:
                return $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
            default:
                return score_t'($urandom);
        endcase
    endfunction

    task automatic send_word(input opcode_t op, input int r, input int c, input score_t v);
        int n;
        if (words_sent < QUIET_FROM && $urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 11);
            @(negedge clk);
            item_if.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        item_if.valid = 1'b1;
        item_if.opcode = op;
        item_if.row = r[ROW_W-1:0];
        item_if.col = c[COL_W-1:0];
        item_if.pixel_value = v;
        do
            @(posedge clk);
        while (!item_if.ready);
        words_sent++;
        if (op == OP_WRITE)
        begin
            score_store[r][c] = v;
            written[r][c] = 1'b1;
        end
        else
            pending_verdicts.push_back(predict_suppression(r, c));
    endtask

    // Fills any never-written pixel of the window before the query goes out.
    task automatic query_pixel(input int r, input int c);
        int hs;
        int he;
        int ws;
        int we;
        if (window_of(r, c, hs, he, ws, we))
            for (int y = hs; y < he; y++)
                for (int x = ws; x < we; x++)
                    if (!written[y][x])
                        send_word(OP_WRITE, y, x, random_score());
        send_word(OP_QUERY, r, c, score_t'($urandom));
    endtask

    task automatic settle_block();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_SIDE:  kernel_reg = data[KSIZE_W-1:0];
            CFG_PLANE_HEIGHT: height_reg = data;
            CFG_PLANE_WIDTH:  width_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] w, input bit touch_unused);
        settle_block();
        write_register(CFG_WINDOW_SIDE, k);
        write_register(CFG_PLANE_HEIGHT, h);
        write_register(CFG_PLANE_WIDTH, w);
        if (touch_unused)
            write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Reset sizes: ties, extreme scores and a corner window clamped to zero.
    task automatic test_default_window();
        send_word(OP_WRITE, 0, 0, SCORE_MAX);
        send_word(OP_WRITE, 1, 1, SCORE_MAX);
        send_word(OP_WRITE, 0, 1, SCORE_MIN);
        query_pixel(0, 0);
        query_pixel(1, 1);
        query_pixel(0, 1);
    endtask

    task automatic test_plane_clipping();
        configure(8'd3, 8'd4, 8'd4, 1'b0);
        query_pixel(3, 3);
        query_pixel(4, 0);
        query_pixel(0, 127);
    endtask

    // Zero sizes, oversized sizes and a write to an index past the last register.
    task automatic test_register_limits();
        configure(8'd0, 8'd0, 8'd0, 1'b1);
        query_pixel(0, 0);
        query_pixel(0, 1);
        configure(8'd1, 8'd255, 8'd200, 1'b0);
        query_pixel(127, 127);
        configure(8'd15, 8'd2, 8'd2, 1'b0);
        query_pixel(1, 1);
    endtask

    task automatic pick_plane_side(output logic [CFG_DATA_W-1:0] side);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            side = CFG_DATA_W'($urandom_range(1, 12));
        else if (pick < 75)
            side = CFG_DATA_W'($urandom_range(13, 127));
        else if (pick < 85)
            side = 8'd128;
        else if (pick < 92)
            side = 8'd0;
        else
            side = CFG_DATA_W'($urandom_range(129, 255));
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] kdata;
        logic [CFG_DATA_W-1:0] hdata;
        logic [CFG_DATA_W-1:0] wdata;
        int pick;
        int h;
        int w;
        int ro;
        int co;
        int r;
        int c;
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    kdata = CFG_DATA_W'($urandom_range(1, 5));
                else if (pick < 80)
                    kdata = CFG_DATA_W'($urandom_range(6, 9));
                else if (pick < 88)
                    kdata = CFG_DATA_W'($urandom_range(10, 15));
                else
                    kdata = 8'd0;
                if ($urandom_range(0, 9) == 0)
                    kdata[CFG_DATA_W-1:KSIZE_W] = (CFG_DATA_W-KSIZE_W)'($urandom);
                pick_plane_side(hdata);
                pick_plane_side(wdata);
                configure(kdata, hdata, wdata, $urandom_range(0, 4) == 0);
            end
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            h = size_limit(int'(height_reg), MAX_HEIGHT_DEF);
            w = size_limit(int'(width_reg), MAX_WIDTH_DEF);
            ro = $urandom_range(0, h - 1);
            co = $urandom_range(0, w - 1);
            repeat ($urandom_range(15, 40))
            begin
                r = ro + $urandom_range(0, 3);
                c = co + $urandom_range(0, 3);
                if (r >= h)
                    r = h - 1;
                if (c >= w)
                    c = w - 1;
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    query_pixel(r, c);
                else if (pick < 14)
                begin
                    if (h < MAX_HEIGHT_DEF)
                        query_pixel($urandom_range(h, 127), $urandom_range(0, 127));
                    else if (w < MAX_WIDTH_DEF)
                        query_pixel($urandom_range(0, 127), $urandom_range(w, 127));
                    else
                        query_pixel(r, c);
                end
                else if (pick < 16)
                    send_word(OP_WRITE, r, c, random_score());
                else if (pick < 18)
                    send_word(OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                              random_score());
                else
                begin
                    send_word(OP_WRITE, r, c,
                              $urandom_range(0, 1) ? SCORE_MAX : score_t'($urandom_range(0, 32767)));
                    query_pixel(r, c);
                end
            end
        end
    endtask

    initial
    begin
        int hold;
        int mode_left;
        bit stalls_on;
        hold = 0;
        mode_left = 0;
        stalls_on = 1'b0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stalls_on = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold > 0)
            begin
                result_if.ready = 1'b0;
                hold--;
            end
            else if (words_sent < QUIET_FROM && stalls_on && $urandom_range(0, 99) < 20)
            begin
                result_if.ready = 1'b0;
                hold = $urandom_range(1, 11) - 1;
            end
            else
                result_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, actual kept_value %0d is_peak %0b",
                         $time, result_if.kept_value, result_if.is_peak);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_if.kept_value !== want.kept_value)
                begin
                    failures++;
                    $display("%0t: kept_value mismatch, expected %0d, actual %0d",
                             $time, want.kept_value, result_if.kept_value);
                end
                if (result_if.is_peak !== want.is_peak)
                begin
                    failures++;
                    $display("%0t: is_peak mismatch, expected %0b, actual %0b",
                             $time, want.is_peak, result_if.is_peak);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW_SIDE;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.opcode = OP_WRITE;
        item_if.row = '0;
        item_if.col = '0;
        item_if.pixel_value = '0;
        kernel_reg = WINDOW_SIDE_RST;
        height_reg = PLANE_HEIGHT_RST;
        width_reg = PLANE_WIDTH_RST;
        words_sent = 0;
        failures = 0;
        idle_cycles = 0;
        gap_pct = 25;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_window();
        test_plane_clipping();
        test_register_limits();
        test_random_traffic();
        settle_block();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
